### rtl/irm_pkg.sv
`timescale 1ns / 1ps

package irm_pkg;

  // Default sizing of the source store and the arithmetic.
  localparam int MAX_DIM_DEF    = 128;
  localparam int PIXEL_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 14;

  // Fixed field widths of the ports.
  localparam int COORD_W    = 8;
  localparam int PIX_PORT_W = 32;
  localparam int DIM_W      = 8;
  localparam int TRIG_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Operation codes of a request.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COSINE_Q14    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SINE_Q14      = 3'd5;

  // Register reset values.
  localparam logic [DIM_W-1:0]         SOURCE_WIDTH_RST  = 8'd128;
  localparam logic [DIM_W-1:0]         SOURCE_HEIGHT_RST = 8'd128;
  localparam logic [DIM_W-1:0]         OUTPUT_WIDTH_RST  = 8'd128;
  localparam logic [DIM_W-1:0]         OUTPUT_HEIGHT_RST = 8'd128;
  localparam logic signed [TRIG_W-1:0] COSINE_RST        = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] SINE_RST          = 16'sd0;

  // Configuration as seen by the mapping pipeline (source sizes already clamped).
  typedef struct packed {
    logic [DIM_W-1:0]         src_w;
    logic [DIM_W-1:0]         src_h;
    logic [DIM_W-1:0]         out_w;
    logic [DIM_W-1:0]         out_h;
    logic signed [TRIG_W-1:0] cosine;
    logic signed [TRIG_W-1:0] sine;
  } irm_cfg_t;

  // Control of the request leaving the mapping pipeline toward the store.
  typedef struct packed {
    logic valid;
    logic fetch;
    logic hit;
    logic write;
  } irm_ctrl_t;

endpackage

### rtl/irm_if.sv
`timescale 1ns / 1ps

// Request channel: load or fetch.
interface irm_req_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [irm_pkg::COORD_W-1:0]      coord_x;
  logic [irm_pkg::COORD_W-1:0]      coord_y;
  logic [irm_pkg::PIX_PORT_W-1:0]   pixel_in;

  modport source (output valid, op, coord_x, coord_y, pixel_in, input ready);
  modport sink   (input valid, op, coord_x, coord_y, pixel_in, output ready);
endinterface

// Result channel: one result per fetch.
interface irm_res_if;
  logic                             valid;
  logic                             ready;
  logic [irm_pkg::PIX_PORT_W-1:0]   pixel_out;
  logic                             inside_res;

  modport source (output valid, pixel_out, inside_res, input ready);
  modport sink   (input valid, pixel_out, inside_res, output ready);
endinterface

### rtl/irm_ram.sv
`timescale 1ns / 1ps

module irm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read; the read register holds while en is low.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

### rtl/irm_map.sv
`timescale 1ns / 1ps

module irm_map #(
  parameter int MAX_DIM    = irm_pkg::MAX_DIM_DEF,
  parameter int PIXEL_BITS = irm_pkg::PIXEL_BITS_DEF,
  parameter int FRAC_BITS  = irm_pkg::FRAC_BITS_DEF,
  localparam int ADDR_W    = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  irm_pkg::irm_cfg_t                cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_op,
  input  logic [irm_pkg::COORD_W-1:0]      in_x,
  input  logic [irm_pkg::COORD_W-1:0]      in_y,
  input  logic [PIXEL_BITS-1:0]            in_pixel,
  input  logic                             take,
  output irm_pkg::irm_ctrl_t               d_ctrl,
  output logic [ADDR_W-1:0]                d_addr,
  output logic [PIXEL_BITS-1:0]            d_pixel
);

  localparam int DIFF_W = irm_pkg::COORD_W + 1;
  localparam int PROD_W = DIFF_W + irm_pkg::TRIG_W;
  localparam int CTR_W  = FRAC_BITS + irm_pkg::DIM_W;
  localparam int SUM_W  = ((CTR_W > PROD_W) ? CTR_W : PROD_W) + 2;
  localparam int HI_W   = SUM_W - FRAC_BITS;
  localparam logic signed [SUM_W-1:0] ONE_Q = SUM_W'(1) << FRAC_BITS;

  // Stage valid bits and per-stage advance.
  logic a_valid, b_valid, c_valid, d_valid;
  logic en_a, en_b, en_c, en_d;

  assign en_d     = !d_valid || take;
  assign en_c     = !c_valid || en_d;
  assign en_b     = !b_valid || en_c;
  assign en_a     = !a_valid || en_b;
  assign in_ready = en_a;

  // Stage A: offsets from the output centre, load address and bounds.
  logic                     a_fetch, a_load_ok;
  logic signed [DIFF_W-1:0] a_dx, a_dy;
  logic [ADDR_W-1:0]        a_addr;
  logic [PIXEL_BITS-1:0]    a_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en_a) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_fetch   <= (in_op == irm_pkg::OP_FETCH);
      a_dx      <= signed'({1'b0, in_x}) - signed'(DIFF_W'(cfg.out_w[7:1]));
      a_dy      <= signed'({1'b0, in_y}) - signed'(DIFF_W'(cfg.out_h[7:1]));
      a_load_ok <= (in_x < cfg.src_w) && (in_y < cfg.src_h);
      a_addr    <= ADDR_W'(in_y) * ADDR_W'(MAX_DIM) + ADDR_W'(in_x);
      a_pixel   <= in_pixel;
    end
  end

  // Stage B: the four rotation products.
  logic                     b_fetch, b_load_ok;
  logic signed [PROD_W-1:0] b_xc, b_ys, b_xs, b_yc;
  logic [ADDR_W-1:0]        b_addr;
  logic [PIXEL_BITS-1:0]    b_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en_b) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_fetch   <= a_fetch;
      b_load_ok <= a_load_ok;
      b_xc      <= PROD_W'(a_dx) * PROD_W'(cfg.cosine);
      b_ys      <= PROD_W'(a_dy) * PROD_W'(cfg.sine);
      b_xs      <= PROD_W'(a_dx) * PROD_W'(cfg.sine);
      b_yc      <= PROD_W'(a_dy) * PROD_W'(cfg.cosine);
      b_addr    <= a_addr;
      b_pixel   <= a_pixel;
    end
  end

  // Stage C: exact source position sums about the source centre.
  logic signed [SUM_W-1:0] ctr_x, ctr_y;
  logic                    c_fetch, c_load_ok;
  logic signed [SUM_W-1:0] c_sx, c_sy;
  logic [ADDR_W-1:0]       c_addr;
  logic [PIXEL_BITS-1:0]   c_pixel;

  assign ctr_x = signed'(SUM_W'(cfg.src_w[7:1])) <<< FRAC_BITS;
  assign ctr_y = signed'(SUM_W'(cfg.src_h[7:1])) <<< FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en_c) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_fetch   <= b_fetch;
      c_load_ok <= b_load_ok;
      c_sx      <= ctr_x + SUM_W'(b_xc) - SUM_W'(b_ys);
      c_sy      <= ctr_y + SUM_W'(b_xs) + SUM_W'(b_yc);
      c_addr    <= b_addr;
      c_pixel   <= b_pixel;
    end
  end

  // Stage D: truncate toward zero, bounds check and fetch address.
  // A sum just below zero truncates to column or row zero.
  logic signed [HI_W-1:0]       hi_x, hi_y, w_s, h_s;
  logic                         neg_x, neg_y, in_x_ok, in_y_ok;
  logic [irm_pkg::COORD_W-1:0]  idx_x, idx_y;
  logic [ADDR_W-1:0]            fetch_addr;
  logic                         d_fetch, d_hit, d_write;

  assign hi_x  = HI_W'(c_sx >>> FRAC_BITS);
  assign hi_y  = HI_W'(c_sy >>> FRAC_BITS);
  assign neg_x = c_sx[SUM_W-1];
  assign neg_y = c_sy[SUM_W-1];
  assign w_s   = signed'(HI_W'(cfg.src_w));
  assign h_s   = signed'(HI_W'(cfg.src_h));

  assign in_x_ok = (cfg.src_w != '0) && (neg_x ? (c_sx > -ONE_Q) : (hi_x < w_s));
  assign in_y_ok = (cfg.src_h != '0) && (neg_y ? (c_sy > -ONE_Q) : (hi_y < h_s));
  assign idx_x   = neg_x ? '0 : hi_x[irm_pkg::COORD_W-1:0];
  assign idx_y   = neg_y ? '0 : hi_y[irm_pkg::COORD_W-1:0];
  assign fetch_addr = ADDR_W'(idx_y) * ADDR_W'(MAX_DIM) + ADDR_W'(idx_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en_d) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_fetch <= c_fetch;
      d_hit   <= c_fetch && in_x_ok && in_y_ok;
      d_write <= !c_fetch && c_load_ok;
      d_addr  <= c_fetch ? fetch_addr : c_addr;
      d_pixel <= c_pixel;
    end
  end

  assign d_ctrl = '{valid: d_valid, fetch: d_fetch, hit: d_hit, write: d_write};

endmodule

### rtl/image_rotate_inverse_map.sv
`timescale 1ns / 1ps

// Channel   Role   Request contents
// req       sink   op (load or fetch), coord_x, coord_y, pixel_in
// res       source pixel_out, inside_res (one per fetch, none per load)
// cfg_*     write  cfg_we, cfg_index (0..5), cfg_wdata
//
// One request enters per cycle while the output is not stalled; a fetch result passes
// through the offset, multiply, sum, bounds/address and store read registers.
// The rate is set by the single store port, used by one load or fetch a cycle.
// Each stage advances when its successor is empty or moving, so a stalled
// result holds in the output stage while earlier stages keep filling.
// Reset is synchronous; it clears valid bits and reloads the registers.
// The source store has no reset: pixels read before being loaded are undefined.

module image_rotate_inverse_map #(
  parameter int MAX_DIM    = irm_pkg::MAX_DIM_DEF,
  parameter int PIXEL_BITS = irm_pkg::PIXEL_BITS_DEF,
  parameter int FRAC_BITS  = irm_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [irm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [irm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  irm_req_if.sink                            req,
  irm_res_if.source                          res
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);

  // Configuration registers.
  logic [irm_pkg::DIM_W-1:0]         source_width, source_height;
  logic [irm_pkg::DIM_W-1:0]         output_width, output_height;
  logic signed [irm_pkg::TRIG_W-1:0] cosine_q14, sine_q14;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= irm_pkg::SOURCE_WIDTH_RST;
      source_height <= irm_pkg::SOURCE_HEIGHT_RST;
      output_width  <= irm_pkg::OUTPUT_WIDTH_RST;
      output_height <= irm_pkg::OUTPUT_HEIGHT_RST;
      cosine_q14    <= irm_pkg::COSINE_RST;
      sine_q14      <= irm_pkg::SINE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        irm_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_wdata[irm_pkg::DIM_W-1:0];
        irm_pkg::REG_SOURCE_HEIGHT: source_height <= cfg_wdata[irm_pkg::DIM_W-1:0];
        irm_pkg::REG_OUTPUT_WIDTH:  output_width  <= cfg_wdata[irm_pkg::DIM_W-1:0];
        irm_pkg::REG_OUTPUT_HEIGHT: output_height <= cfg_wdata[irm_pkg::DIM_W-1:0];
        irm_pkg::REG_COSINE_Q14:    cosine_q14    <= signed'(cfg_wdata);
        irm_pkg::REG_SINE_Q14:      sine_q14      <= signed'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  // Source sizes clamped to the store dimension.
  irm_pkg::irm_cfg_t cfg;

  assign cfg.src_w  = (32'(source_width) > MAX_DIM) ? irm_pkg::DIM_W'(MAX_DIM) : source_width;
  assign cfg.src_h  = (32'(source_height) > MAX_DIM) ? irm_pkg::DIM_W'(MAX_DIM)
                                                      : source_height;
  assign cfg.out_w  = output_width;
  assign cfg.out_h  = output_height;
  assign cfg.cosine = cosine_q14;
  assign cfg.sine   = sine_q14;

  // Mapping pipeline.
  irm_pkg::irm_ctrl_t     d_ctrl;
  logic [ADDR_W-1:0]      d_addr;
  logic [PIXEL_BITS-1:0]  d_pixel;
  logic                   e_valid, e_inside, en_e;
  logic [PIXEL_BITS-1:0]  rdata;

  assign en_e = !e_valid || res.ready;

  irm_map #(
    .MAX_DIM    (MAX_DIM),
    .PIXEL_BITS (PIXEL_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_map (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .in_op    (req.op),
    .in_x     (req.coord_x),
    .in_y     (req.coord_y),
    .in_pixel (req.pixel_in[PIXEL_BITS-1:0]),
    .take     (en_e),
    .d_ctrl   (d_ctrl),
    .d_addr   (d_addr),
    .d_pixel  (d_pixel)
  );

  // Source store: loads and fetches use the port in request order.
  irm_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (en_e),
    .we    (d_ctrl.valid && d_ctrl.write),
    .addr  (d_addr),
    .wdata (d_pixel),
    .rdata (rdata)
  );

  // Output stage: the store read register carries the pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en_e) begin
      e_valid <= d_ctrl.valid && d_ctrl.fetch;
    end
  end

  always_ff @(posedge clk) begin
    if (en_e) begin
      e_inside <= d_ctrl.hit;
    end
  end

  assign res.valid      = e_valid;
  assign res.inside_res = e_inside;
  assign res.pixel_out  = e_inside ? irm_pkg::PIX_PORT_W'(rdata) : '0;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_DIM         = irm_pkg::MAX_DIM_DEF;
  localparam int FRAC            = irm_pkg::FRAC_BITS_DEF;
  localparam int COORD_W         = irm_pkg::COORD_W;
  localparam int PIX_PORT_W      = irm_pkg::PIX_PORT_W;
  localparam int DIM_W           = irm_pkg::DIM_W;
  localparam int TRIG_W          = irm_pkg::TRIG_W;
  localparam int CFG_IDX_W       = irm_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W      = irm_pkg::CFG_DATA_W;
  localparam int PIPE_LATENCY    = 8;
  localparam int HOLD_CYCLES     = 400;
  localparam int RANDOM_PHASES   = 9;
  localparam int ITEMS_PER_PHASE = 56;

  // Indexes past the last register; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [DIM_W-1:0]         src_w;
    logic [DIM_W-1:0]         src_h;
    logic [DIM_W-1:0]         out_w;
    logic [DIM_W-1:0]         out_h;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } geom_t;

  typedef struct {
    bit                    hold_point;
    logic                  op;
    logic [COORD_W-1:0]    x;
    logic [COORD_W-1:0]    y;
    logic [PIX_PORT_W-1:0] pix;
  } req_item_t;

  typedef struct {
    logic [PIX_PORT_W-1:0] pixel;
    logic                  hit;
  } pixel_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  irm_req_if req_ch ();
  irm_res_if res_ch ();

  image_rotate_inverse_map dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  req_item_t       pending_requests[$];
  pixel_result_t   expected_pixels[$];
  int              fetches_in_flight;
  int              errors;
  int              send_idle_pct;
  int              recv_idle_pct;
  bit              hold_go;
  logic            hold_on;

  // Geometry as the stimulus side sees it, and which store entries it has loaded.
  geom_t           gen_geom;
  bit              gen_written [MAX_DIM*MAX_DIM];

  // Predictor state: geometry and source store as the block should hold them.
  geom_t           model_geom;
  logic [PIX_PORT_W-1:0] model_store [MAX_DIM*MAX_DIM];

  function automatic geom_t reset_geom();
    geom_t g;
    g.src_w = irm_pkg::SOURCE_WIDTH_RST;
    g.src_h = irm_pkg::SOURCE_HEIGHT_RST;
    g.out_w = irm_pkg::OUTPUT_WIDTH_RST;
    g.out_h = irm_pkg::OUTPUT_HEIGHT_RST;
    g.cos_v = irm_pkg::COSINE_RST;
    g.sin_v = irm_pkg::SINE_RST;
    return g;
  endfunction

  function automatic geom_t apply_reg(geom_t g, logic [CFG_IDX_W-1:0] idx,
                                      logic [CFG_DATA_W-1:0] d);
    case (idx)
      irm_pkg::REG_SOURCE_WIDTH: begin
        g.src_w = d[DIM_W-1:0];
      end
      irm_pkg::REG_SOURCE_HEIGHT: begin
        g.src_h = d[DIM_W-1:0];
      end
      irm_pkg::REG_OUTPUT_WIDTH: begin
        g.out_w = d[DIM_W-1:0];
      end
      irm_pkg::REG_OUTPUT_HEIGHT: begin
        g.out_h = d[DIM_W-1:0];
      end
      irm_pkg::REG_COSINE_Q14: begin
        g.cos_v = d;
      end
      irm_pkg::REG_SINE_Q14: begin
        g.sin_v = d;
      end
      default: begin
      end
    endcase
    return g;
  endfunction

  // Source sizes above the store dimension are clamped.
  function automatic longint eff_dim(logic [DIM_W-1:0] d);
    return (d > MAX_DIM) ? longint'(MAX_DIM) : longint'(d);
  endfunction

  // Drop the fraction bits, truncating toward zero.
  function automatic longint trunc_q(longint s);
    if (s >= 0) begin
      return s >>> FRAC;
    end
    return -((-s) >>> FRAC);
  endfunction

  // Inverse rotation of an output position into the source image.
  function automatic void map_point(input geom_t g, input logic [COORD_W-1:0] x,
                                    input logic [COORD_W-1:0] y, output bit hit,
                                    output int addr);
    longint w, h, dx, dy, sum_x, sum_y, sx, sy;
    w = eff_dim(g.src_w);
    h = eff_dim(g.src_h);
    dx = longint'(x) - longint'(g.out_w >> 1);
    dy = longint'(y) - longint'(g.out_h >> 1);
    sum_x = (w / 2) * (longint'(1) << FRAC) + dx * longint'($signed(g.cos_v))
            - dy * longint'($signed(g.sin_v));
    sum_y = (h / 2) * (longint'(1) << FRAC) + dx * longint'($signed(g.sin_v))
            + dy * longint'($signed(g.cos_v));
    sx = trunc_q(sum_x);
    sy = trunc_q(sum_y);
    hit = (sx >= 0) && (sy >= 0) && (sx < w) && (sy < h);
    addr = hit ? int'(sy * MAX_DIM + sx) : 0;
  endfunction

  // Expected result of a fetch against the predictor's store.
  function automatic pixel_result_t rotate_lookup(logic [COORD_W-1:0] x,
                                                  logic [COORD_W-1:0] y);
    pixel_result_t r;
    bit hit;
    int addr;
    map_point(model_geom, x, y, hit, addr);
    r.hit = hit;
    r.pixel = hit ? model_store[addr] : '0;
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] pick_source_dim();
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      return DIM_W'($urandom_range(1, 16));
    end else if (r < 85) begin
      return DIM_W'($urandom_range(17, 128));
    end
    case ($urandom_range(0, 3))
      0: return DIM_W'(0);
      1: return DIM_W'(1);
      2: return DIM_W'(128);
      default: return DIM_W'($urandom_range(129, 255));
    endcase
  endfunction

  // Output sizes mostly a little larger than the source, as a rotation needs.
  function automatic logic [DIM_W-1:0] pick_output_dim(logic [DIM_W-1:0] src);
    int r, t;
    r = $urandom_range(99);
    if (r < 65) begin
      t = int'(eff_dim(src)) + int'($urandom_range(0, 8));
      return DIM_W'((t > 255) ? 255 : t);
    end else if (r < 95) begin
      return DIM_W'($urandom_range(1, 255));
    end
    return DIM_W'(0);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    gen_geom = apply_reg(gen_geom, idx, d);
  endtask

  // Writes all six registers, then a spare one; size fields get junk in unused upper bits.
  task automatic set_geometry(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                              input logic [DIM_W-1:0] ow, input logic [DIM_W-1:0] oh,
                              input logic signed [TRIG_W-1:0] c,
                              input logic signed [TRIG_W-1:0] s);
    write_reg(irm_pkg::REG_SOURCE_WIDTH, {8'($urandom), sw});
    write_reg(irm_pkg::REG_SOURCE_HEIGHT, {8'($urandom), sh});
    write_reg(irm_pkg::REG_OUTPUT_WIDTH, {8'($urandom), ow});
    write_reg(irm_pkg::REG_OUTPUT_HEIGHT, {8'($urandom), oh});
    write_reg(irm_pkg::REG_COSINE_Q14, c);
    write_reg(irm_pkg::REG_SINE_Q14, s);
    write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_load(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [PIX_PORT_W-1:0] pix);
    req_item_t it;
    it.hold_point = 1'b0;
    it.op = irm_pkg::OP_LOAD;
    it.x = x;
    it.y = y;
    it.pix = pix;
    pending_requests.push_back(it);
    if (x < eff_dim(gen_geom.src_w) && y < eff_dim(gen_geom.src_h)) begin
      gen_written[int'(y) * MAX_DIM + int'(x)] = 1'b1;
    end
  endtask

  // A fetch that lands on a never-loaded pixel is preceded by a load of that pixel.
  task automatic queue_fetch(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    req_item_t it;
    bit hit;
    int addr;
    map_point(gen_geom, x, y, hit, addr);
    if (hit && !gen_written[addr]) begin
      queue_load(COORD_W'(addr % MAX_DIM), COORD_W'(addr / MAX_DIM), $urandom);
    end
    it.hold_point = 1'b0;
    it.op = irm_pkg::OP_FETCH;
    it.x = x;
    it.y = y;
    it.pix = $urandom;
    pending_requests.push_back(it);
  endtask

  task automatic queue_pause();
    req_item_t it;
    it.hold_point = 1'b1;
    it.op = irm_pkg::OP_LOAD;
    it.x = '0;
    it.y = '0;
    it.pix = '0;
    pending_requests.push_back(it);
  endtask

  // Waits until every request is taken and every result is back, then lets loads settle.
  task automatic drain();
    do begin
      @(negedge clk);
    end while (pending_requests.size() != 0 || req_ch.valid || fetches_in_flight != 0);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic random_phase(input bit with_pause);
    logic [DIM_W-1:0]         sw, sh, ow, oh;
    logic signed [TRIG_W-1:0] c, s;
    logic [COORD_W-1:0]       x, y;
    int                       ew, eh, r, t, lim_x, lim_y;
    sw = pick_source_dim();
    sh = pick_source_dim();
    ow = pick_output_dim(sw);
    oh = pick_output_dim(sh);
    r = $urandom_range(99);
    if (r < 40) begin
      case ($urandom_range(0, 7))
        0: begin c = 16'sd16384;  s = 16'sd0;      end
        1: begin c = 16'sd0;      s = 16'sd16384;  end
        2: begin c = -16'sd16384; s = 16'sd0;      end
        3: begin c = 16'sd0;      s = -16'sd16384; end
        4: begin c = 16'sd11585;  s = 16'sd11585;  end
        5: begin c = 16'sd14189;  s = 16'sd8192;   end
        6: begin c = 16'sd8192;   s = -16'sd14189; end
        default: begin c = -16'sd11585; s = -16'sd11585; end
      endcase
    end else if (r < 80) begin
      t = int'($urandom_range(0, 32768)) - 16384;
      c = t[TRIG_W-1:0];
      t = int'($urandom_range(0, 32768)) - 16384;
      s = t[TRIG_W-1:0];
    end else begin
      c = TRIG_W'($urandom);
      s = TRIG_W'($urandom);
    end
    set_geometry(sw, sh, ow, oh, c, s);
    ew = int'(eff_dim(sw));
    eh = int'(eff_dim(sh));
    lim_x = (int'(ow) + 3 > 255) ? 255 : int'(ow) + 3;
    lim_y = (int'(oh) + 3 > 255) ? 255 : int'(oh) + 3;
    @(negedge clk);
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      if (with_pause && i == ITEMS_PER_PHASE / 2) begin
        queue_pause();
      end
      if ($urandom_range(99) < 35) begin
        if (ew > 0 && eh > 0 && $urandom_range(99) < 85) begin
          x = COORD_W'($urandom_range(0, ew - 1));
          y = COORD_W'($urandom_range(0, eh - 1));
        end else begin
          x = COORD_W'($urandom);
          y = COORD_W'($urandom);
        end
        queue_load(x, y, $urandom);
      end else begin
        if ($urandom_range(99) < 75) begin
          x = COORD_W'($urandom_range(0, lim_x));
          y = COORD_W'($urandom_range(0, lim_y));
        end else begin
          x = COORD_W'($urandom);
          y = COORD_W'($urandom);
        end
        queue_fetch(x, y);
      end
    end
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("image_rotate_inverse_map test failed");
    $finish;
  end

  // Long receiver hold-off, counted here while the sender keeps offering.
  initial begin
    hold_on = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Request driver: offers the oldest pending item, idling at random.
  always @(posedge clk) begin : drive_requests
    req_item_t it;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      // A pause point is passed once no fetch result is outstanding.
      if (pending_requests.size() != 0 && pending_requests[0].hold_point &&
          fetches_in_flight == 0 && !(req_ch.valid && req_ch.op == irm_pkg::OP_FETCH)) begin
        void'(pending_requests.pop_front());
      end
      if (pending_requests.size() != 0 && !pending_requests[0].hold_point &&
          $urandom_range(99) >= send_idle_pct) begin
        it = pending_requests.pop_front();
        req_ch.valid    <= 1'b1;
        req_ch.op       <= it.op;
        req_ch.coord_x  <= it.x;
        req_ch.coord_y  <= it.y;
        req_ch.pixel_in <= it.pix;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks results, predicts from accepted requests, tracks register writes.
  always @(posedge clk) begin : watch_block
    pixel_result_t got, want;
    bit res_taken, fetch_taken;
    if (rst) begin
      res_ch.ready <= 1'b0;
      fetches_in_flight <= 0;
      model_geom = reset_geom();
    end else begin
      res_taken   = res_ch.valid && res_ch.ready;
      fetch_taken = req_ch.valid && req_ch.ready && req_ch.op == irm_pkg::OP_FETCH;
      if (res_taken) begin
        got.pixel = res_ch.pixel_out;
        got.hit   = res_ch.inside_res;
        if (expected_pixels.size() == 0) begin
          if (errors < 10) begin
            $display("unexpected result: pixel %h inside %b", got.pixel, got.hit);
          end
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          if (got.pixel !== want.pixel || got.hit !== want.hit) begin
            if (errors < 10) begin
              $display("mismatch: pixel %h inside %b, expected pixel %h inside %b",
                       got.pixel, got.hit, want.pixel, want.hit);
            end
            errors++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        if (req_ch.op == irm_pkg::OP_LOAD) begin
          if (req_ch.coord_x < eff_dim(model_geom.src_w) &&
              req_ch.coord_y < eff_dim(model_geom.src_h)) begin
            model_store[int'(req_ch.coord_y) * MAX_DIM + int'(req_ch.coord_x)] =
              req_ch.pixel_in;
          end
        end else begin
          expected_pixels.push_back(rotate_lookup(req_ch.coord_x, req_ch.coord_y));
        end
      end
      if (cfg_we) begin
        model_geom = apply_reg(model_geom, cfg_index, cfg_wdata);
      end
      fetches_in_flight <= fetches_in_flight + int'(fetch_taken) - int'(res_taken);
      res_ch.ready <= !hold_on && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Main sequence: reset, directed phases, random phases, final check.
  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    req_ch.valid    = 1'b0;
    req_ch.op       = irm_pkg::OP_LOAD;
    req_ch.coord_x  = '0;
    req_ch.coord_y  = '0;
    req_ch.pixel_in = '0;
    res_ch.ready    = 1'b0;
    hold_go         = 1'b0;
    errors          = 0;
    send_idle_pct   = 35;
    recv_idle_pct   = 62;
    gen_geom        = reset_geom();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset geometry is an identity map: corners, and loads and fetches past the edge.
    @(negedge clk);
    queue_load(8'd0, 8'd0, 32'h0000_0000);
    queue_load(8'd127, 8'd127, 32'hFFFF_FFFF);
    queue_load(8'd127, 8'd0, 32'hA5A5_A5A5);
    queue_load(8'd0, 8'd127, 32'h5A5A_5A5A);
    queue_load(8'd128, 8'd3, $urandom);
    queue_load(8'd255, 8'd255, $urandom);
    queue_fetch(8'd0, 8'd0);
    queue_fetch(8'd127, 8'd127);
    queue_fetch(8'd127, 8'd0);
    queue_fetch(8'd0, 8'd127);
    queue_fetch(8'd128, 8'd0);
    queue_fetch(8'd255, 8'd255);
    drain();

    // Cosine just above one: a sum just below zero truncates to row and column zero.
    set_geometry(8'd2, 8'd2, 8'd2, 8'd2, 16'sd16385, 16'sd0);
    @(negedge clk);
    queue_fetch(8'd0, 8'd0);
    queue_fetch(8'd1, 8'd1);
    queue_fetch(8'd255, 8'd0);
    queue_load(8'd2, 8'd0, $urandom);
    drain();

    // Zero source width: loads are dropped and nothing is inside.
    set_geometry(8'd0, 8'd5, 8'd10, 8'd10, 16'sd16384, 16'sd0);
    @(negedge clk);
    queue_load(8'd0, 8'd0, $urandom);
    queue_fetch(8'd5, 8'd5);
    queue_fetch(8'd0, 8'd0);
    drain();

    // Oversized source and extreme trigonometric values.
    set_geometry(8'd200, 8'd255, 8'd255, 8'd255, 16'sh8000, 16'sd32767);
    @(negedge clk);
    queue_fetch(8'd0, 8'd0);
    queue_fetch(8'd255, 8'd255);
    queue_fetch(8'd127, 8'd127);
    queue_fetch(8'd0, 8'd255);
    drain();

    for (int k = 0; k < RANDOM_PHASES; k++) begin
      @(negedge clk);
      if (k == RANDOM_PHASES / 3) begin
        send_idle_pct = 62;
        recv_idle_pct = 35;
      end else if (k == 2 * RANDOM_PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go = 1'b1;
      end
      random_phase(k == 1 || k == 4 || k == 7);
      drain();
    end

    repeat (PIPE_LATENCY * 4) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $display("%0d expected results never arrived", expected_pixels.size());
      errors += expected_pixels.size();
    end
    if (errors == 0) begin
      $display("image_rotate_inverse_map test passed");
    end else begin
      $display("image_rotate_inverse_map test failed");
    end
    $finish;
  end

endmodule

### image_rotate_inverse_map.f
rtl/irm_pkg.sv
rtl/irm_if.sv
rtl/irm_ram.sv
rtl/irm_map.sv
rtl/image_rotate_inverse_map.sv
tb/tb_top.sv
